// ===== rtl/der_sig_pkg.sv =====
// ----------------------------------------------------------------------------
// der_sig_pkg
// shared types and constants of the der signature parser
// ----------------------------------------------------------------------------
package der_sig_pkg;

  localparam logic [7:0] SEQ_TAG = 8'h30;
  localparam logic [7:0] INT_TAG = 8'h02;

  localparam logic [8:0] POS_MAX = 9'd511;

  localparam logic [1:0] KIND_R       = 2'd0;
  localparam logic [1:0] KIND_S       = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // output queue depth, a power of two and at least two
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       valid_res;
    logic       last_result;
  } res_t;

endpackage

// ===== rtl/der_sig_in_if.sv =====
// ----------------------------------------------------------------------------
// der_sig_in_if
// input byte channel of the der signature parser
// ----------------------------------------------------------------------------
interface der_sig_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== rtl/der_sig_out_if.sv =====
// ----------------------------------------------------------------------------
// der_sig_out_if
// result channel of the der signature parser
// ----------------------------------------------------------------------------
interface der_sig_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       valid_res;
  logic       last_result;

  modport source (output valid, output out_byte, output kind, output valid_res,
                  output last_result, input ready);
  modport sink   (input valid, input out_byte, input kind, input valid_res,
                  input last_result, output ready);
endinterface

// ===== rtl/der_signature_parse.sv =====
// ----------------------------------------------------------------------------
// der_signature_parse
// streaming layout check of a der encoded ecdsa signature
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one byte of the encoded buffer per transaction, the final
//   byte flagged by end_of_buffer. out_ch carries r content bytes (kind 0),
//   s content bytes (kind 1) and, on the final byte, one verdict (kind 2,
//   valid_res set when the signature is well formed, last_result set).
//   r bytes sent before a failure is detected stay sent; the verdict tells
//   the consumer to drop them. trailing bytes after s are ignored.
// timing and throughput:
//   a byte is parsed in the cycle it is accepted and its results enter a
//   four-entry output queue; the first result is visible in the next cycle.
//   one byte is taken per cycle while in_ch.ready is high. a final byte that
//   also carries a content byte yields two results, which costs the output
//   side an extra read; otherwise the rate is one byte per cycle, set by
//   the queue's one read port per cycle.
// reset and stall:
//   rst clears the parse state and empties the queue. when the receiver
//   stalls, the queue fills and in_ch.ready drops once fewer than two free
//   entries remain; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module der_signature_parse
  import der_sig_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  der_sig_in_if.sink   in_ch,
  der_sig_out_if.source out_ch
);

  // parse state
  logic [8:0] byte_position;
  logic [7:0] sequence_length;
  logic [7:0] r_length;
  logic [7:0] s_length;
  logic       failed;

  logic [8:0] byte_position_next;
  logic [7:0] sequence_length_next;
  logic [7:0] r_length_next;
  logic [7:0] s_length_next;
  logic       failed_next;

  // output queue
  res_t             queue [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic       accept;
  logic       pop;
  logic       emit_content;
  logic [1:0] content_kind;
  logic       emit_verdict;
  logic       ok;
  res_t       res0;
  res_t       res1;
  logic [1:0] push_n;

  // widened comparands
  logic [9:0] pos_w;
  logic [9:0] lr_w;
  logic [9:0] ls_w;
  logic [9:0] seq_sum;
  logic [9:0] need_end;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  // room for two results so any byte can be taken
  assign in_ch.ready = (count <= CNT_W'(OUT_DEPTH - 2));

  assign pos_w = {1'b0, byte_position};
  assign lr_w  = {2'b00, r_length};
  assign ls_w  = {2'b00, s_length};

  // the sequence length check uses the length byte being parsed
  assign seq_sum = lr_w + {2'b00, in_ch.data_byte} + 10'd4;

  always_comb begin
    sequence_length_next = sequence_length;
    r_length_next        = r_length;
    s_length_next        = s_length;
    failed_next          = failed;
    emit_content         = 1'b0;
    content_kind         = KIND_R;

    if (byte_position == 9'd0) begin
      if (in_ch.data_byte != SEQ_TAG) failed_next = 1'b1;
    end else if (byte_position == 9'd1) begin
      sequence_length_next = in_ch.data_byte;
    end else if (byte_position == 9'd2) begin
      if (in_ch.data_byte != INT_TAG) failed_next = 1'b1;
    end else if (byte_position == 9'd3) begin
      r_length_next = in_ch.data_byte;
      if (in_ch.data_byte == 8'd0) failed_next = 1'b1;
    end else if (pos_w < lr_w + 10'd4) begin
      // r content
      emit_content = !failed;
      content_kind = KIND_R;
    end else if (pos_w == lr_w + 10'd4) begin
      if (in_ch.data_byte != INT_TAG) failed_next = 1'b1;
    end else if (pos_w == lr_w + 10'd5) begin
      s_length_next = in_ch.data_byte;
      if (in_ch.data_byte == 8'd0) failed_next = 1'b1;
      if ({2'b00, sequence_length} != seq_sum) failed_next = 1'b1;
    end else if (pos_w < lr_w + ls_w + 10'd6) begin
      // s content
      emit_content = !failed;
      content_kind = KIND_S;
    end
  end

  // verdict looks at the state as this byte leaves it
  assign need_end = {2'b00, r_length_next} + {2'b00, s_length_next} + 10'd5;
  assign ok = !failed_next && (s_length_next != 8'd0) && (pos_w >= need_end);
  assign emit_verdict = in_ch.end_of_buffer;

  assign byte_position_next = (byte_position < POS_MAX) ? byte_position + 9'd1 : POS_MAX;

  always_comb begin
    res1.out_byte    = 8'd0;
    res1.kind        = KIND_VERDICT;
    res1.valid_res   = ok;
    res1.last_result = 1'b1;
    if (emit_content) begin
      res0.out_byte    = in_ch.data_byte;
      res0.kind        = content_kind;
      res0.valid_res   = 1'b0;
      res0.last_result = 1'b0;
    end else begin
      res0 = res1;
    end
    if (!accept) begin
      push_n = 2'd0;
    end else begin
      push_n = {1'b0, emit_content} + {1'b0, emit_verdict};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      sequence_length <= '0;
      r_length        <= '0;
      s_length        <= '0;
      failed          <= 1'b0;
    end else if (accept) begin
      if (in_ch.end_of_buffer) begin
        // next byte opens a new buffer
        byte_position   <= '0;
        sequence_length <= '0;
        r_length        <= '0;
        s_length        <= '0;
        failed          <= 1'b0;
      end else begin
        byte_position   <= byte_position_next;
        sequence_length <= sequence_length_next;
        r_length        <= r_length_next;
        s_length        <= s_length_next;
        failed          <= failed_next;
      end
    end
  end

  // queue storage, one or two writes per cycle
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue[wr_ptr] <= res0;
    if (push_n == 2'd2) queue[wr_ptr + PTR_W'(1)] <= res1;
  end

  always_comb begin
    count_next = count + CNT_W'(push_n);
    if (pop) count_next = count_next - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

  assign out_ch.valid       = (count != '0);
  assign out_ch.out_byte    = queue[rd_ptr].out_byte;
  assign out_ch.kind        = queue[rd_ptr].kind;
  assign out_ch.valid_res   = queue[rd_ptr].valid_res;
  assign out_ch.last_result = queue[rd_ptr].last_result;

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(OUT_DEPTH))
    else $error("output queue overflow");

  // a final byte returns the parser to its start
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_buffer |=> byte_position == 9'd0 && !failed && s_length == 8'd0)
    else $error("parse state not cleared after end of buffer");

  // failure is sticky within a buffer
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && failed && !in_ch.end_of_buffer |=> failed)
    else $error("failure flag dropped inside a buffer");

  // a byte with end of buffer always queues a verdict
  a_verdict_pushed: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.end_of_buffer |-> push_n != 2'd0)
    else $error("verdict not queued");

endmodule

// ===== tb/der_signature_parse_tb.sv =====
// ----------------------------------------------------------------------------
// der_signature_parse_tb
// self-checking bench for the streaming der signature layout check
// ----------------------------------------------------------------------------
// encoded signature buffers go in one byte per transaction. Most are well
// formed, with random r and s content. The rest carry one flaw each, or are
// plain noise. A byte-level parse model predicts every r/s content byte and
// the verdict, and the monitor checks results in order. The run goes through
// phases of sender idling and receiver stalls. One phase holds the receiver
// off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module der_signature_parse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import der_sig_pkg::*;

  // traffic phases, in run order
  typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH, PH_PRESS} phase_e;

  // ways a generated signature can be broken
  typedef enum int {
    FL_NONE, FL_SEQ_TAG, FL_R_TAG, FL_S_TAG, FL_ZERO_R, FL_ZERO_S, FL_LEN, FL_TRUNC
  } flaw_e;

  typedef struct {
    logic [7:0] data;
    logic       eob;
    phase_e     ph;
  } byte_txn_t;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off in the pressure phase
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_ITEMS   = 180;
  localparam int PHASE_ITEMS  = RAND_ITEMS / 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  der_sig_in_if  in_if ();
  der_sig_out_if out_if ();

  der_signature_parse dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #2 clk = ~clk;

  // pending input bytes and expected results
  byte_txn_t  stim_q[$];
  logic [7:0] build_q[$];
  res_t       exp_res_q[$];

  int     err_cnt     = 0;
  int     quiet_cycles = 0;
  logic   in_fire     = 1'b0;
  phase_e cur_phase   = PH_NONE;

  // ---------------------------------------------------------------------------
  // parse model state: byte position in the buffer, declared lengths, failure
  // ---------------------------------------------------------------------------
  logic [8:0] sig_pos = '0;
  logic [7:0] seq_len = '0;
  logic [7:0] r_len   = '0;
  logic [7:0] s_len   = '0;
  logic       sig_bad = 1'b0;

  task automatic push_expected(input logic [7:0] b, input logic [1:0] k, input logic ok,
                               input logic last);
    res_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.valid_res   = ok;
    r.last_result = last;
    exp_res_q.push_back(r);
  endtask

  // advance the parse by one accepted byte, queueing whatever it yields
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    int   p;
    int   lr;
    logic ok;
    p  = int'(sig_pos);
    lr = int'(r_len);
    if (p == 0) begin
      if (b != SEQ_TAG) sig_bad = 1'b1;
    end else if (p == 1) begin
      seq_len = b;
    end else if (p == 2) begin
      if (b != INT_TAG) sig_bad = 1'b1;
    end else if (p == 3) begin
      r_len = b;
      if (b == 8'd0) sig_bad = 1'b1;
    end else if (p < 4 + lr) begin
      // r content passes through only while nothing has failed
      if (!sig_bad) push_expected(b, KIND_R, 1'b0, 1'b0);
    end else if (p == 4 + lr) begin
      if (b != INT_TAG) sig_bad = 1'b1;
    end else if (p == 5 + lr) begin
      s_len = b;
      if (b == 8'd0) sig_bad = 1'b1;
      // sequence length has to cover both integers and their two headers
      if (int'(seq_len) != lr + int'(b) + 4) sig_bad = 1'b1;
    end else if (p < 6 + lr + int'(s_len)) begin
      if (!sig_bad) push_expected(b, KIND_S, 1'b0, 1'b0);
    end
    // anything past s is trailing and ignored

    if (eob) begin
      // buffer must have reached the last s byte for a clean verdict
      ok = !sig_bad && (s_len != 8'd0) && (p >= 5 + int'(r_len) + int'(s_len));
      push_expected(8'd0, KIND_VERDICT, ok, 1'b1);
      sig_pos = '0;
      seq_len = '0;
      r_len   = '0;
      s_len   = '0;
      sig_bad = 1'b0;
    end else begin
      sig_pos = (sig_pos < POS_MAX) ? sig_pos + 9'd1 : POS_MAX;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] other_than(input logic [7:0] tag);
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == tag) v = ~tag;
    return v;
  endfunction

  // move the assembled buffer into the input queue, end flag on its last byte
  task automatic send_buf(input phase_e ph);
    byte_txn_t t;
    for (int i = 0; i < build_q.size(); i++) begin
      t.data = build_q[i];
      t.eob  = (i == build_q.size() - 1);
      t.ph   = ph;
      stim_q.push_back(t);
    end
    build_q.delete();
  endtask

  // one signature buffer with random content, optionally broken in one spot;
  // n_used returns the bytes that are not trailing
  task automatic add_sig(input int rl, input int sl, input flaw_e flaw, input int n_trail,
                         input phase_e ph, output int n_used);
    int seq;
    int cut;
    if (flaw == FL_ZERO_R) rl = 0;
    if (flaw == FL_ZERO_S) sl = 0;
    seq = rl + sl + 4;
    if (flaw == FL_LEN) seq = seq + $urandom_range(1, 255);
    build_q.push_back(flaw == FL_SEQ_TAG ? other_than(SEQ_TAG) : SEQ_TAG);
    build_q.push_back(8'(seq));
    build_q.push_back(flaw == FL_R_TAG ? other_than(INT_TAG) : INT_TAG);
    build_q.push_back(8'(rl));
    repeat (rl) build_q.push_back(8'($urandom_range(0, 255)));
    build_q.push_back(flaw == FL_S_TAG ? other_than(INT_TAG) : INT_TAG);
    build_q.push_back(8'(sl));
    repeat (sl) build_q.push_back(8'($urandom_range(0, 255)));
    n_used = build_q.size();
    // truncation covers both short buffers and a cut inside s
    if (flaw == FL_TRUNC) begin
      cut = $urandom_range(1, build_q.size() - 1);
      while (build_q.size() > cut) void'(build_q.pop_back());
      n_used = cut;
    end else begin
      repeat (n_trail) build_q.push_back(8'($urandom_range(0, 255)));
    end
    send_buf(ph);
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, 40);
    return $urandom_range(1, 6);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents the next byte at the falling edge, holds it until taken
  // ---------------------------------------------------------------------------
  function automatic bit src_idle(input phase_e ph);
    case (ph)
      PH_SRC:  return $urandom_range(0, 99) < 54;
      PH_BOTH: return $urandom_range(0, 99) < 29;
      default: return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin : drive_bytes
    byte_txn_t t;
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (stim_q.size() > 0 && !src_idle(stim_q[0].ph)) begin
        t = stim_q.pop_front();
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= t.data;
        in_if.end_of_buffer <= t.eob;
        cur_phase           <= t.ph;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready: random stalls per phase, plus one long hold-off when the
  // pressure phase begins so the output queue fills and the input backs up
  // ---------------------------------------------------------------------------
  int   hold_cnt   = 0;
  logic press_done = 1'b0;

  function automatic bit sink_stall(input phase_e ph);
    case (ph)
      PH_SNK:  return $urandom_range(0, 99) < 54;
      PH_BOTH: return $urandom_range(0, 99) < 29;
      default: return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else if (cur_phase == PH_PRESS && !press_done) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= HOLD_CYCLES;
      press_done   <= 1'b1;
    end else begin
      out_if.ready <= !sink_stall(cur_phase);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transaction, then feeds accepted bytes to the
  // parse model; the result check comes first at each edge
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_cnt < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_result();
    res_t want;
    if (exp_res_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                out_if.kind, out_if.out_byte));
      return;
    end
    want = exp_res_q.pop_front();
    if (out_if.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %02h, expected %02h", out_if.out_byte,
                                want.out_byte));
    if (out_if.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", out_if.kind, want.kind));
    if (out_if.valid_res !== want.valid_res)
      report_mismatch($sformatf("valid_res %0b, expected %0b", out_if.valid_res,
                                want.valid_res));
    if (out_if.last_result !== want.last_result)
      report_mismatch($sformatf("last_result %0b, expected %0b", out_if.last_result,
                                want.last_result));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) check_result();
      if (in_if.valid && in_if.ready) parse_byte(in_if.data_byte, in_if.end_of_buffer);
    end
  end

  // watchdog: ends the run once nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : main
    int     used;
    int     counted;
    int     pick;
    phase_e ph;

    in_if.valid         = 1'b0;
    in_if.data_byte     = 8'd0;
    in_if.end_of_buffer = 1'b0;
    out_if.ready        = 1'b0;

    // directed: one-byte buffer, shorter than the header
    build_q.push_back(SEQ_TAG);
    send_buf(PH_NONE);
    // smallest well-formed signature, content bytes at both extremes
    build_q.push_back(SEQ_TAG); build_q.push_back(8'h06);
    build_q.push_back(INT_TAG); build_q.push_back(8'h01); build_q.push_back(8'hff);
    build_q.push_back(INT_TAG); build_q.push_back(8'h01); build_q.push_back(8'h00);
    send_buf(PH_NONE);
    // buffer ends on the s length byte: s truncated
    build_q.push_back(SEQ_TAG); build_q.push_back(8'h06);
    build_q.push_back(INT_TAG); build_q.push_back(8'h01); build_q.push_back(8'h80);
    build_q.push_back(INT_TAG); build_q.push_back(8'h01);
    send_buf(PH_NONE);
    // sequence length off by one: r goes out, then failure holds back s
    build_q.push_back(SEQ_TAG); build_q.push_back(8'h07);
    build_q.push_back(INT_TAG); build_q.push_back(8'h01); build_q.push_back(8'h7f);
    build_q.push_back(INT_TAG); build_q.push_back(8'h01); build_q.push_back(8'h01);
    send_buf(PH_NONE);

    // one large buffer: the longest r/s that still fit, then a trailing tail
    // long enough to saturate the position
    add_sig(200, 51, FL_NONE, 257, PH_NONE, used);

    // random buffers through the idling phases
    counted = 0;
    while (counted < RAND_ITEMS) begin
      ph   = phase_e'(PH_SRC + ((counted / PHASE_ITEMS < 3) ? counted / PHASE_ITEMS : 3));
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        add_sig(pick_len(), pick_len(), FL_NONE,
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, ph, used);
      end else if (pick < 90) begin
        add_sig(pick_len(), pick_len(), flaw_e'($urandom_range(FL_SEQ_TAG, FL_TRUNC)),
                ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, ph, used);
      end else begin
        // noise, sometimes starting with a plausible tag
        used = $urandom_range(1, 8);
        build_q.push_back($urandom_range(0, 1) ? SEQ_TAG : 8'($urandom_range(0, 255)));
        repeat (used - 1) build_q.push_back(8'($urandom_range(0, 255)));
        send_buf(ph);
      end
      counted += used;
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // drain: everything sent, everything expected has come back
    do @(negedge clk);
    while (stim_q.size() != 0 || in_if.valid || exp_res_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
